>>> hw/rtl/lrrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrrs_pkg
// Shared types and codes for the line range remap search block.
// ----------------------------------------------------------------------------
package lrrs_pkg;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int IDX_BITS    = 7;
    localparam int COUNT_BITS  = 8;
    localparam int QUEUE_DEPTH = 2;

    // command codes on the input tuser
    localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_FWD   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_REV   = 2'd2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_WRITTEN   = 2'd0,
        ST_MAPPED    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_SKIPPED   = 2'd3
    } status_t;

    // decoded operation
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_FWD,
        OP_REV,
        OP_NONE
    } op_t;

    // classification handed from the front end to the back end
    typedef struct packed {
        op_t  op;
        logic slot_ok;
    } front_ctl_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PROBE,
        BK_XLATE
    } back_state_t;

endpackage : lrrs_pkg
`default_nettype wire

>>> hw/rtl/lrrs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrrs_front
// Accept input beats and classify them for the back end queue.
// ----------------------------------------------------------------------------
module lrrs_front
    import lrrs_pkg::*;
#(
    parameter int NUM_ENTRIES = 128
) (
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [CMD_BITS-1:0] s_tuser,
    input  wire logic [IDX_BITS-1:0] entry_index,
    input  wire logic                q_full,
    output logic                     q_push,
    output front_ctl_t               q_ctl
);

    localparam int CMP_BITS = $clog2(NUM_ENTRIES + 1) + IDX_BITS;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        case (s_tuser)
            CMD_WRITE: q_ctl.op = OP_WRITE;
            CMD_FWD:   q_ctl.op = OP_FWD;
            CMD_REV:   q_ctl.op = OP_REV;
            default:   q_ctl.op = OP_NONE;
        endcase
        // drop writes to slots beyond the table
        q_ctl.slot_ok = CMP_BITS'(entry_index) < CMP_BITS'(NUM_ENTRIES);
    end

endmodule : lrrs_front
`default_nettype wire

>>> hw/rtl/lrrs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrrs_queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lrrs_queue
    import lrrs_pkg::*;
#(
    parameter int WIDTH = 139
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic      [WIDTH-1:0] rdata
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_BITS'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule : lrrs_queue
`default_nettype wire

>>> hw/rtl/lrrs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrrs_back
// Range table, binary search sequencer, translation and result register.
// ----------------------------------------------------------------------------
module lrrs_back
    import lrrs_pkg::*;
#(
    parameter int NUM_ENTRIES  = 128,
    parameter int LINE_BITS    = 24,
    parameter int PATH_ID_BITS = 8
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           q_valid,
    input  wire front_ctl_t                                     q_ctl,
    input  wire logic [IDX_BITS+4*LINE_BITS+PATH_ID_BITS+LINE_BITS:0] q_data,
    output logic                                                q_pop,
    input  wire logic [COUNT_BITS-1:0]                          entry_count,
    input  wire logic                                           m_tready,
    output logic                                                m_tvalid,
    output status_t                                             res_status,
    output logic      [LINE_BITS-1:0]                           res_line,
    output logic      [PATH_ID_BITS-1:0]                        res_pid,
    output logic                                                res_pres
);

    localparam int ADDR_BITS = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int BND_BITS  = $clog2(NUM_ENTRIES + 1);
    localparam int ROW_BITS  = 4 * LINE_BITS + PATH_ID_BITS + 1;
    localparam int CMP_BITS  = ((BND_BITS > COUNT_BITS) ? BND_BITS : COUNT_BITS) + 1;
    localparam int L         = LINE_BITS;

    // table storage: {present, path id, local end, local begin, remote end, remote begin}
    logic [ROW_BITS-1:0] mem [NUM_ENTRIES];
    logic [ROW_BITS-1:0] row_reg;

    back_state_t          state_reg, state_next;
    logic                 fwd_reg, fwd_next;
    logic [L-1:0]         qline_reg, qline_next;
    logic [BND_BITS-1:0]  lo_reg, lo_next;
    logic [BND_BITS-1:0]  hi_reg, hi_next;
    logic [ADDR_BITS-1:0] mid_reg, mid_next;
    logic [L-1:0]         diff_reg, diff_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [L-1:0]            out_line_reg, out_line_next;
    logic [PATH_ID_BITS-1:0] out_pid_reg, out_pid_next;
    logic                    out_pres_reg, out_pres_next;

    // head of queue
    logic [IDX_BITS-1:0] head_idx;
    logic [ROW_BITS-1:0] head_row;
    logic [L-1:0]        head_qline;

    // probe datapath
    logic [L-1:0]            rb, re, lb, le, kb, ke, tb, te;
    logic [PATH_ID_BITS-1:0] row_pid;
    logic                    row_pres;
    logic                    hit, go_low, window_open, out_free;
    logic [BND_BITS-1:0]     n_search, mid_b, mid_plus, lo_probe, hi_probe;
    logic [BND_BITS-1:0]     lo_sel, hi_sel;
    logic [BND_BITS:0]       mid_sum;
    logic [ADDR_BITS-1:0]    mid_new;
    logic [L:0]              xl_sum;
    logic [L-1:0]            xl_line;

    // memory control
    logic                 rd_en, wr_en, load;

    assign head_idx   = q_data[IDX_BITS-1:0];
    assign head_row   = q_data[IDX_BITS +: ROW_BITS];
    assign head_qline = q_data[IDX_BITS+ROW_BITS +: L];

    assign rb       = row_reg[0   +: L];
    assign re       = row_reg[L   +: L];
    assign lb       = row_reg[2*L +: L];
    assign le       = row_reg[3*L +: L];
    assign row_pid  = row_reg[4*L +: PATH_ID_BITS];
    assign row_pres = row_reg[4*L+PATH_ID_BITS];

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        kb = fwd_reg ? rb : lb;
        ke = fwd_reg ? re : le;
        tb = fwd_reg ? lb : rb;
        te = fwd_reg ? le : re;

        hit    = (qline_reg >= kb) && (qline_reg <= ke);
        go_low = qline_reg < kb;

        mid_b       = BND_BITS'(mid_reg);
        mid_plus    = mid_b + BND_BITS'(1);
        lo_probe    = go_low ? lo_reg : mid_plus;
        hi_probe    = go_low ? mid_b : hi_reg;
        window_open = lo_probe < hi_probe;

        // clamp the searched count to the table depth
        n_search = (CMP_BITS'(entry_count) > CMP_BITS'(NUM_ENTRIES))
                   ? BND_BITS'(NUM_ENTRIES) : BND_BITS'(entry_count);

        lo_sel  = (state_reg == BK_IDLE) ? '0 : lo_probe;
        hi_sel  = (state_reg == BK_IDLE) ? n_search : hi_probe;
        mid_sum = (BND_BITS+1)'(lo_sel) + (BND_BITS+1)'(hi_sel) - (BND_BITS+1)'(1);
        mid_new = mid_sum[ADDR_BITS:1];

        // offset translation, saturating at the line maximum
        xl_sum = (L+1)'(diff_reg) + (L+1)'(tb);
        if (tb == te)
        begin
            xl_line = tb;
        end
        else if (xl_sum[L])
        begin
            xl_line = '1;
        end
        else
        begin
            xl_line = xl_sum[L-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free && (q_ctl.op == OP_FWD || q_ctl.op == OP_REV)
                    && n_search != '0)
                begin
                    state_next = BK_PROBE;
                end
            end
            BK_PROBE:
            begin
                if (hit)
                begin
                    state_next = BK_XLATE;
                end
                else if (!window_open && out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_XLATE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        load            = 1'b0;
        fwd_next        = fwd_reg;
        qline_next      = qline_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        diff_next       = diff_reg;
        out_status_next = ST_NOT_FOUND;
        out_line_next   = '0;
        out_pid_next    = '0;
        out_pres_next   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_ctl.op)
                        OP_WRITE:
                        begin
                            wr_en           = q_ctl.slot_ok;
                            load            = 1'b1;
                            out_status_next = ST_WRITTEN;
                        end
                        OP_FWD, OP_REV:
                        begin
                            fwd_next   = q_ctl.op == OP_FWD;
                            qline_next = head_qline;
                            lo_next    = '0;
                            hi_next    = n_search;
                            mid_next   = mid_new;
                            rd_en      = 1'b1;
                            load       = n_search == '0;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            BK_PROBE:
            begin
                diff_next = qline_reg - kb;
                if (!hit)
                begin
                    if (window_open)
                    begin
                        lo_next  = lo_probe;
                        hi_next  = hi_probe;
                        mid_next = mid_new;
                        rd_en    = 1'b1;
                    end
                    else
                    begin
                        load = out_free;
                    end
                end
            end
            BK_XLATE:
            begin
                load          = out_free;
                out_pid_next  = row_pid;
                out_pres_next = row_pres;
                if (fwd_reg && !row_pres)
                begin
                    out_status_next = ST_SKIPPED;
                end
                else
                begin
                    out_status_next = ST_MAPPED;
                    out_line_next   = xl_line;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg   <= fwd_next;
        qline_reg <= qline_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        diff_reg  <= diff_next;
        if (load)
        begin
            out_status_reg <= out_status_next;
            out_line_reg   <= out_line_next;
            out_pid_reg    <= out_pid_next;
            out_pres_reg   <= out_pres_next;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ADDR_BITS'(head_idx)] <= head_row;
        end
        if (rd_en)
        begin
            row_reg <= mem[mid_new];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_line   = out_line_reg;
    assign res_pid    = out_pid_reg;
    assign res_pres   = out_pres_reg;

endmodule : lrrs_back
`default_nettype wire

>>> hw/rtl/line_range_remap_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_range_remap_search
// Range table that translates line numbers between remote and local numbering.
// ----------------------------------------------------------------------------
// Flow: a write, an unused command or a query of an empty table is answered
//   without a search; a query probes the table by binary search, at most
//   floor(log2(NUM_ENTRIES)) + 1 probes (8 for 128 entries), and a hit adds a
//   translation step. The back end handles one item at a time; a 2-deep queue
//   keeps input beats flowing.
// Reset: rst_n clears control and entry_count; the table is undefined until written.
// ----------------------------------------------------------------------------
module line_range_remap_search
    import lrrs_pkg::*;
#(
    parameter int NUM_ENTRIES  = 128,
    parameter int LINE_BITS    = 24,
    parameter int PATH_ID_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // entry_count register
    input  wire logic                  cfg_we,
    input  wire logic [COUNT_BITS-1:0] cfg_wdata,

    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // from bit 0: entry index, remote first line, remote last line, local first
    // line, local last line, path_id_in, path_present_in, query_line, zero pad
    input  wire logic [((IDX_BITS + 5*LINE_BITS + PATH_ID_BITS + 1 + 7) / 8) * 8 - 1:0]
                                       s_tdata,
    // command
    input  wire logic [CMD_BITS-1:0]   s_tuser,

    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // from bit 0: mapped_line, path_id_out, path_present_out, zero pad
    output logic [((LINE_BITS + PATH_ID_BITS + 1 + 7) / 8) * 8 - 1:0]
                                       m_tdata,
    // status
    output logic [STATUS_BITS-1:0]     m_tuser
);

    localparam int IN_BITS  = IDX_BITS + 5 * LINE_BITS + PATH_ID_BITS + 1;
    localparam int OUT_W    = ((LINE_BITS + PATH_ID_BITS + 1 + 7) / 8) * 8;
    localparam int CTL_BITS = $bits(front_ctl_t);
    localparam int Q_WIDTH  = CTL_BITS + IN_BITS;

    logic [COUNT_BITS-1:0] entry_count_reg;

    // front end to queue
    front_ctl_t         push_ctl;
    logic               q_push;
    logic               q_full;
    logic [Q_WIDTH-1:0] q_wdata;

    // queue to back end
    logic               q_valid;
    logic               q_pop;
    logic [Q_WIDTH-1:0] q_rdata;
    front_ctl_t         head_ctl;
    logic [IN_BITS-1:0] head_data;

    // result register fields
    status_t                 res_status;
    logic [LINE_BITS-1:0]    res_line;
    logic [PATH_ID_BITS-1:0] res_pid;
    logic                    res_pres;

    // Hold the searched entry count; software must write it only while idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    // Front end: take the beat when the queue has room and decode the command.
    lrrs_front #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .entry_index (s_tdata[IDX_BITS-1:0]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_ctl       (push_ctl)
    );

    // Queue the classification together with the raw payload.
    assign q_wdata = {push_ctl, s_tdata[IN_BITS-1:0]};

    lrrs_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    assign head_ctl  = front_ctl_t'(q_rdata[IN_BITS +: CTL_BITS]);
    assign head_data = q_rdata[IN_BITS-1:0];

    // Back end: table writes, binary search and the result register; it takes no
    // item from the queue while a finished result waits downstream.
    lrrs_back #(
        .NUM_ENTRIES  (NUM_ENTRIES),
        .LINE_BITS    (LINE_BITS),
        .PATH_ID_BITS (PATH_ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ctl       (head_ctl),
        .q_data      (head_data),
        .q_pop       (q_pop),
        .entry_count (entry_count_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .res_status  (res_status),
        .res_line    (res_line),
        .res_pid     (res_pid),
        .res_pres    (res_pres)
    );

    // Pack the result beat; pad bits stay zero.
    assign m_tdata = OUT_W'({res_pres, res_pid, res_line});
    assign m_tuser = res_status;

`ifndef ASSERT_OFF
    // The back end pops only an occupied queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // An item leaves the queue only when the result register can take a beat.
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!m_tvalid || m_tready))
        else $error("queue popped while result register blocked");

    // Write done and not found carry all-zero data.
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_WRITTEN || m_tuser == ST_NOT_FOUND))
            |-> (m_tdata == '0))
        else $error("nonzero data on write done or not found");

    // Skipped means no path and no translated line.
    a_skip_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_SKIPPED)
            |-> (m_tdata[LINE_BITS-1:0] == '0 && !m_tdata[LINE_BITS+PATH_ID_BITS]))
        else $error("skipped result with line or path flag set");
`endif

endmodule : line_range_remap_search
`default_nettype wire
